/* src/dtdur_pkg.sv */
// ----------------------------------------------------------------------------
// dtdur_pkg
// shared widths, constants, microcode store and calendar helpers for the
// date-time plus duration adder
// ----------------------------------------------------------------------------
package dtdur_pkg;

  // stream widths
  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 64;

  // saturation bound on the day part of a duration
  localparam int MAX_DURATION_DAYS = 32767;

  // internal widths
  localparam int YEAR_W  = 16;
  localparam int MON_W   = 19;
  localparam int MIC_W   = 28;
  localparam int TIME_W  = 9;
  localparam int DAY_W   = 17;
  localparam int YMOD_W  = 9;
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int PC_W    = 4;

  // calendar constants
  localparam int MONTHS_PER_YEAR  = 12;
  localparam int MIN_PER_HOUR     = 60;
  localparam int HOURS_PER_DAY    = 24;
  localparam int MICRO_PER_SEC    = 1000000;
  localparam int MICRO_PER_MIN    = 60000000;
  localparam int LEAP_CYCLE       = 400;

  // month sum is biased to stay positive: bias is a multiple of twelve, minus one
  localparam int YEAR_BIAS        = 11000;
  localparam int MON_BIAS         = YEAR_BIAS * MONTHS_PER_YEAR - 1;
  // year is biased positive before its remainder by 400 is taken
  localparam int YEAR_MOD_BIAS    = 70 * LEAP_CYCLE;

  // reciprocal multipliers, each under by at most one after the shift
  localparam int RECIP_12    = 87381;
  localparam int SHIFT_12    = 20;
  localparam int Q12_W       = 15;
  localparam int RECIP_400   = 83886;
  localparam int SHIFT_400   = 25;
  localparam int Q400_W      = 8;
  localparam int RECIP_MICRO = 68719;
  localparam int SHIFT_MICRO = 36;
  localparam int QSEC_W      = 6;

  // month numbers
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    OP_MUL_MON,
    OP_FIX_MON,
    OP_MUL_YEAR,
    OP_FIX_YEAR,
    OP_WRAP_MIC,
    OP_MUL_SEC,
    OP_FIX_SEC,
    OP_WRAP_MIN,
    OP_WRAP_HOUR,
    OP_CLAMP,
    OP_FOLD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_MIC_OUT,
    COND_MIN_OUT,
    COND_HOUR_OUT,
    COND_DAY_OUT,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             last;
  } uword_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_MUL_MON   = 4'd0;
  localparam logic [PC_W-1:0] PC_FIX_MON   = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_YEAR  = 4'd2;
  localparam logic [PC_W-1:0] PC_FIX_YEAR  = 4'd3;
  localparam logic [PC_W-1:0] PC_WRAP_MIC  = 4'd4;
  localparam logic [PC_W-1:0] PC_MUL_SEC   = 4'd5;
  localparam logic [PC_W-1:0] PC_FIX_SEC   = 4'd6;
  localparam logic [PC_W-1:0] PC_WRAP_MIN  = 4'd7;
  localparam logic [PC_W-1:0] PC_WRAP_HOUR = 4'd8;
  localparam logic [PC_W-1:0] PC_CLAMP     = 4'd9;
  localparam logic [PC_W-1:0] PC_FOLD      = 4'd10;
  localparam logic [PC_W-1:0] PC_EMIT      = 4'd11;

  // control store: a taken condition jumps to target, else the next step, or idle after the last one
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    begin
      w = '{op: OP_EMIT, cond: COND_OUT_FULL, target: PC_EMIT, last: 1'b1};
      case (pc)
        PC_MUL_MON:   w = '{OP_MUL_MON,   COND_NEVER,    PC_MUL_MON,   1'b0};
        PC_FIX_MON:   w = '{OP_FIX_MON,   COND_NEVER,    PC_FIX_MON,   1'b0};
        PC_MUL_YEAR:  w = '{OP_MUL_YEAR,  COND_NEVER,    PC_MUL_YEAR,  1'b0};
        PC_FIX_YEAR:  w = '{OP_FIX_YEAR,  COND_NEVER,    PC_FIX_YEAR,  1'b0};
        PC_WRAP_MIC:  w = '{OP_WRAP_MIC,  COND_MIC_OUT,  PC_WRAP_MIC,  1'b0};
        PC_MUL_SEC:   w = '{OP_MUL_SEC,   COND_NEVER,    PC_MUL_SEC,   1'b0};
        PC_FIX_SEC:   w = '{OP_FIX_SEC,   COND_NEVER,    PC_FIX_SEC,   1'b0};
        PC_WRAP_MIN:  w = '{OP_WRAP_MIN,  COND_MIN_OUT,  PC_WRAP_MIN,  1'b0};
        PC_WRAP_HOUR: w = '{OP_WRAP_HOUR, COND_HOUR_OUT, PC_WRAP_HOUR, 1'b0};
        PC_CLAMP:     w = '{OP_CLAMP,     COND_NEVER,    PC_CLAMP,     1'b0};
        PC_FOLD:      w = '{OP_FOLD,      COND_DAY_OUT,  PC_FOLD,      1'b0};
        PC_EMIT:      w = '{OP_EMIT,      COND_OUT_FULL, PC_EMIT,      1'b1};
        default:      w = '{OP_EMIT,      COND_OUT_FULL, PC_EMIT,      1'b1};
      endcase
      return w;
    end
  endfunction

  // length of a month, months 1 to 12
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap_year);
    logic [4:0] len;
    begin
      case (month)
        MONTH_FEB: len = leap_year ? 5'd29 : 5'd28;
        MONTH_APR: len = 5'd30;
        MONTH_JUN: len = 5'd30;
        MONTH_SEP: len = 5'd30;
        MONTH_NOV: len = 5'd30;
        default:   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

/* src/datetime_duration_adder_top.sv */
// ----------------------------------------------------------------------------
// datetime_duration_adder_top
// adds a signed duration to a gregorian date-time, one result beat per input
// beat, using a small microcoded sequencer over a shared datapath
// ----------------------------------------------------------------------------
// one input beat carries a start date-time and a duration; one output beat
// carries their sum. months wrap with a year carry, the time of day wraps
// with floor carries into the day, the start day is clamped to the new
// month's length and the day count is then folded one month per cycle until
// it fits. the block works on one beat at a time: an item runs the fixed
// steps after its accepting edge, repeats the microsecond, minute and hour
// wrap steps until each value is in range, repeats the fold step once for
// each month crossed, and holds the emit step while the output register is
// full; s_tready rises the cycle after the emit step, so a new beat is taken
// only once the last one is through. the month folding loop takes longest:
// a day part of +-32767 crosses about 1076 months. a finished result sits in
// an output register, so the next input beat is taken while the result
// waits.
// s_tready is low while an item is in work and during reset.
// ----------------------------------------------------------------------------
module datetime_duration_adder_top (
  input  logic                              clk,
  input  logic                              rst,
  // start_year[14:0], start_month[18:15], start_day[23:19], start_hour[28:24],
  // start_minute[34:29], start_micro_in_minute[60:35], dur_total_months[78:61],
  // dur_days[94:79], dur_hours[100:95], dur_minutes[107:101],
  // dur_micro_in_minute[134:108], zero pad[135]
  input  logic [dtdur_pkg::S_DATA_W-1:0]    s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // result_negative[0], result_year[16:1], result_month[20:17],
  // result_day[25:21], result_hour[30:26], result_minute[36:31],
  // result_second[42:37], result_microsecond[62:43], zero pad[63]
  output logic [dtdur_pkg::M_DATA_W-1:0]    m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready
);
  import dtdur_pkg::*;

  // input fields
  logic signed [14:0] start_year;
  logic [3:0]         start_month;
  logic [4:0]         start_day;
  logic [4:0]         start_hour;
  logic [5:0]         start_minute;
  logic [25:0]        start_micro_in_minute;
  logic signed [17:0] dur_total_months;
  logic signed [15:0] dur_days;
  logic signed [5:0]  dur_hours;
  logic signed [6:0]  dur_minutes;
  logic signed [26:0] dur_micro_in_minute;

  assign start_year            = s_tdata[14:0];
  assign start_month           = s_tdata[18:15];
  assign start_day             = s_tdata[23:19];
  assign start_hour            = s_tdata[28:24];
  assign start_minute          = s_tdata[34:29];
  assign start_micro_in_minute = s_tdata[60:35];
  assign dur_total_months      = s_tdata[78:61];
  assign dur_days              = s_tdata[94:79];
  assign dur_hours             = s_tdata[100:95];
  assign dur_minutes           = s_tdata[107:101];
  assign dur_micro_in_minute   = s_tdata[134:108];

  // sequencer
  logic            busy;
  logic            busy_next;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uword;
  logic            cond_hit;
  logic            accept;
  logic            emit;

  // datapath registers
  logic [MON_W-1:0]         mon_sum;
  logic signed [YEAR_W-1:0] year;
  logic [3:0]               month;
  logic [YMOD_W-1:0]        year_mod;
  logic signed [MIC_W-1:0]  mic;
  logic signed [TIME_W-1:0] minute;
  logic signed [TIME_W-1:0] hour;
  logic signed [DAY_W-1:0]  day;
  logic [4:0]               sday;
  logic [PROD_W-1:0]        prod;
  logic [5:0]               second;
  logic [19:0]              micro;

  // output register
  logic                     out_valid;
  logic                     out_valid_next;
  logic [M_DATA_W-1:0]      out_data;

  // load values
  logic [19:0]              mon_load;
  logic signed [20:0]       dur_days_ext;
  logic signed [20:0]       dur_days_sat;

  // shared multiplier operands
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;

  // month fix-up
  logic [Q12_W-1:0]         q12;
  logic [MON_W-1:0]         rem12;
  logic [YEAR_W-1:0]        q12_fix;
  logic [3:0]               month_fix;

  // year remainder by 400
  logic [YEAR_W-1:0]        year_u;
  logic [Q400_W-1:0]        q400;
  logic [16:0]              rem400;
  logic [YMOD_W-1:0]        ymod_fix;

  // seconds split
  logic [QSEC_W-1:0]        qsec;
  logic [25:0]              rem_sec;
  logic [5:0]               second_fix;
  logic [19:0]              micro_fix;

  // range checks for the wrap steps
  logic mic_lo, mic_hi, min_lo, min_hi, hour_lo, hour_hi, day_lo, day_hi;

  // calendar
  logic                     leap_year;
  logic [4:0]               len_cur;
  logic [4:0]               len_prev;
  logic signed [DAY_W-1:0]  len_cur_s;
  logic [4:0]               sday_clamp;
  logic [YMOD_W-1:0]        ymod_inc;
  logic [YMOD_W-1:0]        ymod_dec;

  assign uword  = ucode_rom(pc);
  assign s_tready = !busy && !rst;
  assign accept = s_tvalid && s_tready;
  assign emit   = busy && (uword.op == OP_EMIT) && !cond_hit;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // load arithmetic
  assign mon_load = 20'(start_month) + 20'(dur_total_months) + 20'(MON_BIAS);

  always_comb begin
    dur_days_ext = 21'(dur_days);
    if (dur_days_ext > 21'(MAX_DURATION_DAYS)) begin
      dur_days_sat = 21'(MAX_DURATION_DAYS);
    end else if (dur_days_ext < -21'(MAX_DURATION_DAYS)) begin
      dur_days_sat = -21'(MAX_DURATION_DAYS);
    end else begin
      dur_days_sat = dur_days_ext;
    end
  end

  // multiplier operand select, one product a step
  always_comb begin
    case (uword.op)
      OP_MUL_MON: begin
        mul_a = MUL_A_W'(mon_sum);
        mul_b = MUL_B_W'(RECIP_12);
      end
      OP_MUL_YEAR: begin
        mul_a = MUL_A_W'(year_u);
        mul_b = MUL_B_W'(RECIP_400);
      end
      default: begin
        mul_a = mic[MUL_A_W-1:0];
        mul_b = MUL_B_W'(RECIP_MICRO);
      end
    endcase
  end

  // month and year carry from the product
  always_comb begin
    q12   = prod[SHIFT_12 +: Q12_W];
    rem12 = mon_sum - MON_W'(q12) * MON_W'(MONTHS_PER_YEAR);
    if (rem12 >= MON_W'(MONTHS_PER_YEAR)) begin
      q12_fix   = YEAR_W'(q12) + 1'b1;
      month_fix = 4'(rem12 - MON_W'(MONTHS_PER_YEAR)) + 4'd1;
    end else begin
      q12_fix   = YEAR_W'(q12);
      month_fix = 4'(rem12) + 4'd1;
    end
  end

  // year modulo 400 from the product
  assign year_u = year + YEAR_W'(YEAR_MOD_BIAS);
  always_comb begin
    q400   = prod[SHIFT_400 +: Q400_W];
    rem400 = 17'(year_u) - 17'(q400) * 17'(LEAP_CYCLE);
    if (rem400 >= 17'(LEAP_CYCLE)) begin
      ymod_fix = YMOD_W'(rem400 - 17'(LEAP_CYCLE));
    end else begin
      ymod_fix = YMOD_W'(rem400);
    end
  end

  // seconds and microseconds from the product
  always_comb begin
    qsec    = prod[SHIFT_MICRO +: QSEC_W];
    rem_sec = mic[25:0] - 26'(qsec) * 26'(MICRO_PER_SEC);
    if (rem_sec >= 26'(MICRO_PER_SEC)) begin
      second_fix = qsec + 1'b1;
      micro_fix  = 20'(rem_sec - 26'(MICRO_PER_SEC));
    end else begin
      second_fix = qsec;
      micro_fix  = 20'(rem_sec);
    end
  end

  assign mic_lo  = mic < 0;
  assign mic_hi  = mic >= MIC_W'(MICRO_PER_MIN);
  assign min_lo  = minute < 0;
  assign min_hi  = minute >= TIME_W'(MIN_PER_HOUR);
  assign hour_lo = hour < 0;
  assign hour_hi = hour >= TIME_W'(HOURS_PER_DAY);

  // leap rule on the tracked year remainder by 400
  assign leap_year = (year_mod[1:0] == 2'b00) && (year_mod != YMOD_W'(100)) &&
                     (year_mod != YMOD_W'(200)) && (year_mod != YMOD_W'(300));
  assign len_cur   = month_days(month, leap_year);
  // the month before january is december of the previous year
  assign len_prev  = (month == MONTH_JAN) ? 5'd31 : month_days(month - 4'd1, leap_year);
  assign len_cur_s = DAY_W'(len_cur);
  assign day_lo    = day < 1;
  assign day_hi    = day > len_cur_s;

  assign ymod_inc = (year_mod == YMOD_W'(LEAP_CYCLE - 1)) ? '0 : year_mod + 1'b1;
  assign ymod_dec = (year_mod == '0) ? YMOD_W'(LEAP_CYCLE - 1) : year_mod - 1'b1;

  always_comb begin
    if (sday > len_cur) begin
      sday_clamp = len_cur;
    end else if (sday == 5'd0) begin
      sday_clamp = 5'd1;
    end else begin
      sday_clamp = sday;
    end
  end

  // condition select for the jump
  always_comb begin
    case (uword.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_MIC_OUT:  cond_hit = mic_lo || mic_hi;
      COND_MIN_OUT:  cond_hit = min_lo || min_hi;
      COND_HOUR_OUT: cond_hit = hour_lo || hour_hi;
      COND_DAY_OUT:  cond_hit = day_lo || day_hi;
      COND_OUT_FULL: cond_hit = out_valid && !m_tready;
      default:       cond_hit = 1'b0;
    endcase
  end

  // step counter and busy flag
  always_comb begin
    busy_next = busy;
    pc_next   = pc;
    if (accept) begin
      busy_next = 1'b1;
      pc_next   = PC_MUL_MON;
    end else if (busy) begin
      if (cond_hit) begin
        pc_next = uword.target;
      end else if (uword.last) begin
        busy_next = 1'b0;
        pc_next   = PC_MUL_MON;
      end else begin
        pc_next = pc + 1'b1;
      end
    end
  end

  // output slot fills on emit, drains on a taken beat
  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= PC_MUL_MON;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath: each control word drives one operation
  always_ff @(posedge clk) begin
    if (accept) begin
      mon_sum <= mon_load[MON_W-1:0];
      year    <= YEAR_W'(start_year);
      mic     <= MIC_W'(start_micro_in_minute) + MIC_W'(dur_micro_in_minute);
      minute  <= TIME_W'(start_minute) + TIME_W'(dur_minutes);
      hour    <= TIME_W'(start_hour) + TIME_W'(dur_hours);
      day     <= DAY_W'(dur_days_sat);
      sday    <= start_day;
    end else if (busy) begin
      case (uword.op)
        OP_MUL_MON, OP_MUL_YEAR, OP_MUL_SEC: begin
          prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        OP_FIX_MON: begin
          month <= month_fix;
          year  <= year + q12_fix - YEAR_W'(YEAR_BIAS);
        end
        OP_FIX_YEAR: begin
          year_mod <= ymod_fix;
        end
        OP_WRAP_MIC: begin
          if (mic_lo) begin
            mic    <= mic + MIC_W'(MICRO_PER_MIN);
            minute <= minute - 1'b1;
          end else if (mic_hi) begin
            mic    <= mic - MIC_W'(MICRO_PER_MIN);
            minute <= minute + 1'b1;
          end
        end
        OP_FIX_SEC: begin
          second <= second_fix;
          micro  <= micro_fix;
        end
        OP_WRAP_MIN: begin
          if (min_lo) begin
            minute <= minute + TIME_W'(MIN_PER_HOUR);
            hour   <= hour - 1'b1;
          end else if (min_hi) begin
            minute <= minute - TIME_W'(MIN_PER_HOUR);
            hour   <= hour + 1'b1;
          end
        end
        OP_WRAP_HOUR: begin
          if (hour_lo) begin
            hour <= hour + TIME_W'(HOURS_PER_DAY);
            day  <= day - 1'b1;
          end else if (hour_hi) begin
            hour <= hour - TIME_W'(HOURS_PER_DAY);
            day  <= day + 1'b1;
          end
        end
        OP_CLAMP: begin
          day <= day + DAY_W'(sday_clamp);
        end
        OP_FOLD: begin
          // borrow the previous month's length, or give back this one's
          if (day_lo) begin
            day <= day + DAY_W'(len_prev);
            if (month == MONTH_JAN) begin
              month    <= MONTH_DEC;
              year     <= year - 1'b1;
              year_mod <= ymod_dec;
            end else begin
              month <= month - 4'd1;
            end
          end else if (day_hi) begin
            day <= day - len_cur_s;
            if (month == MONTH_DEC) begin
              month    <= MONTH_JAN;
              year     <= year + 1'b1;
              year_mod <= ymod_inc;
            end else begin
              month <= month + 4'd1;
            end
          end
        end
        OP_EMIT: begin
          if (emit) begin
            out_data <= {1'b0, micro, second, minute[5:0], hour[4:0], day[4:0], month,
                         year, year[YEAR_W-1]};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // an accepted beat starts the program at its first step
  ap_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (busy && pc == PC_MUL_MON))
    else $error("accepted beat did not start the sequencer");

  // a completed emit step leaves the sequencer idle with a result shown
  ap_emit_done: assert property (@(posedge clk) disable iff (rst)
    emit |=> (m_tvalid && !busy))
    else $error("emit step did not present a result");

  // folding leaves a valid month
  ap_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:17] >= 4'd1 && m_tdata[20:17] <= 4'd12))
    else $error("result month out of range");

  // time-of-day carries fully wrapped
  ap_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:26] < 5'd24 && m_tdata[36:31] < 6'd60 &&
                  m_tdata[42:37] < 6'd60))
    else $error("result time of day out of range");

endmodule
